### sv/utf8_strict_decoder_defines.svh
// Assertion macros used by the strict UTF-8 decoder top level.
`ifndef UTF8_STRICT_DECODER_DEFINES_SVH
`define UTF8_STRICT_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
`define UTF8SD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define UTF8SD_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define UTF8SD_ASSERT(label, prop, msg)
`define UTF8SD_ASSERT_RST(label, prop, msg)
`endif

`endif

### sv/utf8sd_pkg.sv
// Types, constants and status codes of the strict UTF-8 decoder.
package utf8sd_pkg;

   localparam int TEXT_BYTES_DEF = 8192;
   localparam int CODE_POINTS_DEF = 8192;

   localparam int CODE_POINT_W = 21;
   localparam int BYTE_END_W = 14;
   localparam int MAX_CHARS_W = 14;
   localparam int LOWER_W = 17;

   localparam logic [MAX_CHARS_W-1:0] MAX_CHARS_RESET = 14'd8192;

   localparam logic [7:0] LEAD2_LO = 8'hC2;
   localparam logic [7:0] LEAD2_HI = 8'hDF;
   localparam logic [7:0] LEAD3_LO = 8'hE0;
   localparam logic [7:0] LEAD3_HI = 8'hEF;
   localparam logic [7:0] LEAD4_LO = 8'hF0;
   localparam logic [7:0] LEAD4_HI = 8'hF4;

   localparam logic [LOWER_W-1:0] BOUND2 = 17'h00080;
   localparam logic [LOWER_W-1:0] BOUND3 = 17'h00800;
   localparam logic [LOWER_W-1:0] BOUND4 = 17'h10000;

   localparam logic [CODE_POINT_W-1:0] CP_MAX = 21'h10FFFF;
   localparam logic [CODE_POINT_W-1:0] SURR_LO = 21'h00D800;
   localparam logic [CODE_POINT_W-1:0] SURR_HI = 21'h00DFFF;

   typedef enum logic [3:0] {
      ST_OK        = 4'd0,
      ST_BAD_LEAD  = 4'd1,
      ST_BAD_CONT  = 4'd2,
      ST_TRUNC     = 4'd3,
      ST_OVERLONG  = 4'd4,
      ST_ABOVE     = 4'd5,
      ST_SURROGATE = 4'd6,
      ST_TOO_MANY  = 4'd7,
      ST_TOO_LONG  = 4'd8
   } status_type;

   // Per-text decoder state whose widths do not depend on parameters.
   typedef struct packed {
      logic [CODE_POINT_W-1:0] partial_value;
      logic [1:0]              bytes_due;
      logic [LOWER_W-1:0]      lower_bound;
      status_type              fault_code;
   } dec_state_type;

   typedef struct packed {
      logic [CODE_POINT_W-1:0] code_point;
      logic [BYTE_END_W-1:0]   byte_end;
      status_type              status;
      logic                    text_done;
   } result_type;

endpackage

### sv/utf8_strict_decoder.sv
// Strict UTF-8 decoder top level: request register, decode step, result register.
//
//  Channel   Ports                         Contents
//  request   req_tvalid/tready/tdata/tlast one text byte, tlast marks the last byte
//  result    rsp_tvalid/tready/tdata/...   code point, byte end, status, text done
//  csr       csr_wen, csr_wdata            max_chars register
//
// One byte per cycle sustained while the result is not stalled; a byte waits in
// the request register, and its result, if any, is then registered. The decode
// step is a single pass of logic between the request register and the result
// register, so state carries from byte to byte without a bubble. Reset clears the
// per-text state and sets max_chars to 8192. A stalled result holds the request
// register, and the request side stalls only when both registers are full.
`include "utf8_strict_decoder_defines.svh"

module utf8_strict_decoder #(
   parameter int MAX_TEXT_BYTES = utf8sd_pkg::TEXT_BYTES_DEF,
   parameter int MAX_CODE_POINTS = utf8sd_pkg::CODE_POINTS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [7:0]                         req_tdata,   // [7:0] text_byte
   input  logic                               req_tlast,   // end_of_text
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [39:0]                        rsp_tdata,   // [20:0] code_point,
                                                           // [34:21] byte_end, zero pad
   output logic [3:0]                         rsp_tuser,   // [3:0] status
   output logic                               rsp_tlast,   // text_done
   input  logic                               csr_wen,
   input  logic [utf8sd_pkg::MAX_CHARS_W-1:0] csr_wdata    // max_chars
);

   localparam int OFS_W = $clog2(MAX_TEXT_BYTES + 1);
   localparam int CNT_W = $clog2(MAX_CODE_POINTS + 1);

   logic                                  in_valid_ff, in_valid_in;
   logic [7:0]                            in_byte_ff;
   logic                                  in_last_ff;
   utf8sd_pkg::dec_state_type             state_ff, state_in;
   logic [OFS_W-1:0]                      offset_ff, offset_in;
   logic [CNT_W-1:0]                      count_ff, count_in;
   logic [utf8sd_pkg::MAX_CHARS_W-1:0]    max_chars_ff;
   logic                                  rsp_valid_ff, rsp_valid_in;
   utf8sd_pkg::result_type                rsp_ff, step_result;
   logic                                  step_emit;
   logic                                  advance;

   // The request in the input register is decoded once the result slot is free.
   assign advance = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_comb begin
      if (advance) begin
         rsp_valid_in = step_emit;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   utf8sd_step #(
      .MAX_TEXT_BYTES  (MAX_TEXT_BYTES),
      .MAX_CODE_POINTS (MAX_CODE_POINTS),
      .OFS_W           (OFS_W),
      .CNT_W           (CNT_W)
   ) u_step (
      .text_byte   (in_byte_ff),
      .end_of_text (in_last_ff),
      .max_chars   (max_chars_ff),
      .state_cur   (state_ff),
      .offset_cur  (offset_ff),
      .count_cur   (count_ff),
      .state_nxt   (state_in),
      .offset_nxt  (offset_in),
      .count_nxt   (count_in),
      .emit        (step_emit),
      .result      (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff <= '0;
         offset_ff <= '0;
         count_ff <= '0;
         max_chars_ff <= utf8sd_pkg::MAX_CHARS_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
            offset_ff <= offset_in;
            count_ff <= count_in;
         end
         if (csr_wen) begin
            max_chars_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (advance && step_emit) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {5'b0, rsp_ff.byte_end, rsp_ff.code_point};
   assign rsp_tuser = rsp_ff.status;
   assign rsp_tlast = rsp_ff.text_done;

   `UTF8SD_ASSERT_RST(a_reset_empties, reset |=> !in_valid_ff && !rsp_valid_ff, "pipeline not empty after reset")
   `UTF8SD_ASSERT(a_fault_zero_cp, rsp_valid_ff && rsp_ff.status != utf8sd_pkg::ST_OK |-> rsp_ff.code_point == '0, "faulted result carries a code point")
   `UTF8SD_ASSERT(a_last_clears, advance && in_last_ff |=> offset_ff == '0 && count_ff == '0 && state_ff.fault_code == utf8sd_pkg::ST_OK, "text state not cleared after last byte")
   `UTF8SD_ASSERT(a_last_emits, advance && in_last_ff |=> rsp_valid_ff && rsp_ff.text_done, "last byte gave no closing result")
   `UTF8SD_ASSERT(a_count_bound, count_ff <= CNT_W'(MAX_CODE_POINTS) && offset_ff <= OFS_W'(MAX_TEXT_BYTES), "character or byte count beyond limit")

endmodule

### sv/utf8sd_step.sv
// Combinational per-byte decode step: next state and optional result.
module utf8sd_step #(
   parameter int MAX_TEXT_BYTES = utf8sd_pkg::TEXT_BYTES_DEF,
   parameter int MAX_CODE_POINTS = utf8sd_pkg::CODE_POINTS_DEF,
   parameter int OFS_W = $clog2(MAX_TEXT_BYTES + 1),
   parameter int CNT_W = $clog2(MAX_CODE_POINTS + 1)
) (
   input  logic [7:0]                          text_byte,
   input  logic                                end_of_text,
   input  logic [utf8sd_pkg::MAX_CHARS_W-1:0]  max_chars,
   input  utf8sd_pkg::dec_state_type           state_cur,
   input  logic [OFS_W-1:0]                    offset_cur,
   input  logic [CNT_W-1:0]                    count_cur,
   output utf8sd_pkg::dec_state_type           state_nxt,
   output logic [OFS_W-1:0]                    offset_nxt,
   output logic [CNT_W-1:0]                    count_nxt,
   output logic                                emit,
   output utf8sd_pkg::result_type              result
);

   localparam int CMP_W = (CNT_W > utf8sd_pkg::MAX_CHARS_W) ? CNT_W : utf8sd_pkg::MAX_CHARS_W;
   localparam logic [OFS_W-1:0] OFS_LIMIT = OFS_W'(MAX_TEXT_BYTES);
   localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_CODE_POINTS);

   utf8sd_pkg::status_type                 new_fault;
   logic                                   done_char;
   logic [utf8sd_pkg::CODE_POINT_W-1:0]    value;
   logic [utf8sd_pkg::CODE_POINT_W-1:0]    shifted;

   assign shifted = {state_cur.partial_value[utf8sd_pkg::CODE_POINT_W-7:0], text_byte[5:0]};

   always_comb begin
      state_nxt = state_cur;
      offset_nxt = offset_cur;
      count_nxt = count_cur;
      new_fault = utf8sd_pkg::ST_OK;
      done_char = 1'b0;
      value = '0;
      emit = 1'b0;
      result = '0;

      if (state_cur.fault_code == utf8sd_pkg::ST_OK) begin
         if (offset_cur >= OFS_LIMIT) begin
            new_fault = utf8sd_pkg::ST_TOO_LONG;
         end else begin
            offset_nxt = offset_cur + OFS_W'(1);
            if (state_cur.bytes_due == 2'd0) begin
               // The character limit is checked before the lead is looked at.
               if (CMP_W'(count_cur) >= CMP_W'(max_chars) || count_cur >= CNT_LIMIT) begin
                  new_fault = utf8sd_pkg::ST_TOO_MANY;
               end else if (text_byte[7] == 1'b0) begin
                  value = utf8sd_pkg::CODE_POINT_W'(text_byte);
                  done_char = 1'b1;
               end else if (text_byte inside {[utf8sd_pkg::LEAD2_LO:utf8sd_pkg::LEAD2_HI]}) begin
                  state_nxt.partial_value = utf8sd_pkg::CODE_POINT_W'(text_byte[4:0]);
                  state_nxt.bytes_due = 2'd1;
                  state_nxt.lower_bound = utf8sd_pkg::BOUND2;
               end else if (text_byte inside {[utf8sd_pkg::LEAD3_LO:utf8sd_pkg::LEAD3_HI]}) begin
                  state_nxt.partial_value = utf8sd_pkg::CODE_POINT_W'(text_byte[3:0]);
                  state_nxt.bytes_due = 2'd2;
                  state_nxt.lower_bound = utf8sd_pkg::BOUND3;
               end else if (text_byte inside {[utf8sd_pkg::LEAD4_LO:utf8sd_pkg::LEAD4_HI]}) begin
                  state_nxt.partial_value = utf8sd_pkg::CODE_POINT_W'(text_byte[2:0]);
                  state_nxt.bytes_due = 2'd3;
                  state_nxt.lower_bound = utf8sd_pkg::BOUND4;
               end else begin
                  new_fault = utf8sd_pkg::ST_BAD_LEAD;
               end
            end else if (text_byte[7:6] != 2'b10) begin
               new_fault = utf8sd_pkg::ST_BAD_CONT;
            end else begin
               state_nxt.partial_value = shifted;
               state_nxt.bytes_due = state_cur.bytes_due - 2'd1;
               if (state_cur.bytes_due == 2'd1) begin
                  value = shifted;
                  if (shifted < utf8sd_pkg::CODE_POINT_W'(state_cur.lower_bound)) begin
                     new_fault = utf8sd_pkg::ST_OVERLONG;
                  end else if (shifted > utf8sd_pkg::CP_MAX) begin
                     new_fault = utf8sd_pkg::ST_ABOVE;
                  end else if (shifted >= utf8sd_pkg::SURR_LO &&
                               shifted <= utf8sd_pkg::SURR_HI) begin
                     new_fault = utf8sd_pkg::ST_SURROGATE;
                  end else begin
                     done_char = 1'b1;
                  end
               end
            end
         end

         if (new_fault == utf8sd_pkg::ST_OK && !done_char && end_of_text &&
             state_nxt.bytes_due != 2'd0) begin
            new_fault = utf8sd_pkg::ST_TRUNC;
         end

         if (new_fault != utf8sd_pkg::ST_OK) begin
            state_nxt.fault_code = new_fault;
            emit = 1'b1;
            result.code_point = '0;
            result.byte_end = utf8sd_pkg::BYTE_END_W'(offset_nxt);
            result.status = new_fault;
            result.text_done = end_of_text;
         end else if (done_char) begin
            count_nxt = count_cur + CNT_W'(1);
            state_nxt.partial_value = '0;
            state_nxt.lower_bound = '0;
            emit = 1'b1;
            result.code_point = value;
            result.byte_end = utf8sd_pkg::BYTE_END_W'(offset_nxt);
            result.status = utf8sd_pkg::ST_OK;
            result.text_done = end_of_text;
         end
      end else if (end_of_text) begin
         // Closing result of a text that already faulted.
         emit = 1'b1;
         result.code_point = '0;
         result.byte_end = utf8sd_pkg::BYTE_END_W'(offset_cur);
         result.status = state_cur.fault_code;
         result.text_done = 1'b1;
      end

      if (end_of_text) begin
         state_nxt = '0;
         offset_nxt = '0;
         count_nxt = '0;
      end
   end

endmodule
